@@ rtl/core/tqe_pkg.sv @@
`default_nettype none

package tqe_pkg;

  localparam int POINT_COUNT = 4096;
  localparam int IDX_W       = $clog2(POINT_COUNT);
  localparam int COORD_BITS  = 16;

  // coordinate differences and their products
  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2 * DW;
  localparam int CRW   = PW + 1;
  localparam int VPW   = DW + CRW;
  localparam int VW    = 54;
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int E_W   = SQ_W + 2;
  localparam int E2_W  = 2 * E_W;
  localparam int E3_W  = 3 * E_W;
  localparam int MAG_W = 3 * COORD_BITS + 4;
  localparam int HALF  = MAG_W / 2;
  localparam int V2_W  = 2 * MAG_W;

  // quality q: largest q with (5625 * E^3) * q^2 <= (2809 * V^2) * 2^34
  localparam int QK_NUM = 2809;
  localparam int QK_DEN = 5625;
  localparam int L_W    = E3_W + 13;
  localparam int M_W    = V2_W + 12;
  localparam int REM_W  = L_W;
  localparam int QW     = 32;
  localparam int DIV_STEPS = QW;
  localparam int ROOT_W = QW / 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] SLOT_A = 2'd0;
  localparam logic [1:0] SLOT_B = 2'd1;
  localparam logic [1:0] SLOT_C = 2'd2;
  localparam logic [1:0] SLOT_D = 2'd3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] z;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } point_t;

  typedef struct packed {
    logic signed [DW-1:0] z;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] x;
  } diff_t;

endpackage

`default_nettype wire

@@ rtl/core/tet_quality_evaluator.sv @@
`default_nettype none

// channel | handshake                 | fields
// --------+---------------------------+----------------------------------------------------
// in      | in_valid_i / in_stall_o   | operation, point_index, coord_x/y/z, vertex_a..d
// out     | out_valid_o / out_stall_i | quality, signed_volume6
//
// A point load is written straight into the store; an evaluate holds the single port point store
// for one read per vertex, and no new input is taken until its last vertex read is issued.
// The long stretch of the result pipeline is the 32-step quotient and 16-step square root
// pipeline behind the store.
// Reset clears control only; store entries are undefined until loaded.
// A stalled result stops the pipeline only when a finished item waits behind it.

module tet_quality_evaluator import tqe_pkg::*; (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire                    operation_i,
  input  wire [IDX_W-1:0]        point_index_i,
  input  wire signed [COORD_BITS-1:0] coord_x_i,
  input  wire signed [COORD_BITS-1:0] coord_y_i,
  input  wire signed [COORD_BITS-1:0] coord_z_i,
  input  wire [IDX_W-1:0]        vertex_a_i,
  input  wire [IDX_W-1:0]        vertex_b_i,
  input  wire [IDX_W-1:0]        vertex_c_i,
  input  wire [IDX_W-1:0]        vertex_d_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output logic [15:0]            quality_o,
  output logic signed [VW-1:0]   signed_volume6_o
);

  function automatic diff_t pdiff(point_t p, point_t q);
    diff_t r;
    r.x = DW'(p.x) - DW'(q.x);
    r.y = DW'(p.y) - DW'(q.y);
    r.z = DW'(p.z) - DW'(q.z);
    return r;
  endfunction

  logic en, accept, acc_load, acc_eval, issue;
  logic [IDX_W-1:0] rd_addr;

  logic             busy_q;
  logic [1:0]       cnt_q;
  logic [IDX_W-1:0] idx_q [3];
  logic             rv_q;
  logic [1:0]       rslot_q;

  point_t store_mem [POINT_COUNT];
  point_t rd_q, pa_q, pb_q, pc_q;

  logic out_valid_q;
  logic [15:0] out_q_q;
  logic signed [VW-1:0] out_vol_q;

  // pipeline stages
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  diff_t                edge_q [6];
  diff_t                e0_2_q, e0_3_q;
  logic signed [PW-1:0] xp_q [6];
  logic [SQ_W-1:0]      sq_q [18];
  logic signed [CRW-1:0] cr_q [3];
  logic [E_W-1:0]       d2_q [6];
  logic signed [VPW-1:0] vp_q [3];
  logic [E_W-1:0]       emax_q, emax5_q;
  logic signed [VW-1:0] vol5_q, vol6_q, vol7_q, vol8_q, vol9_q;
  logic [E2_W-1:0]      e2_q;
  logic [MAG_W-1:0]     mag_q;
  logic [E2_W-1:0]      e3p_q [2];
  logic [2*HALF-1:0]    vh_q, vm_q, vl_q;
  logic [E3_W-1:0]      e3_q;
  logic                 z7_q, z8_q, z9_q;
  logic [V2_W-1:0]      v2sq_q;
  logic [L_W-1:0]       l8_q, l9_q;
  logic [M_W-1:0]       m_q;

  logic [E_W-1:0] emax_d;

  // quotient stages
  logic                 dv_q   [DIV_STEPS+1];
  logic [REM_W-1:0]     drem_q [DIV_STEPS+1];
  logic [REM_W-1:0]     drem_d [DIV_STEPS+1];
  logic [REM_W:0]       dsh    [DIV_STEPS+1];
  logic [L_W-1:0]       dl_q   [DIV_STEPS+1];
  logic [QW-1:0]        dqt_q  [DIV_STEPS+1];
  logic [QW-1:0]        dqt_d  [DIV_STEPS+1];
  logic                 dsat_q [DIV_STEPS+1];
  logic                 dz_q   [DIV_STEPS+1];
  logic signed [VW-1:0] dvol_q [DIV_STEPS+1];

  // square root stages
  logic                 sv_q    [ROOT_W+1];
  logic [QW-1:0]        srad_q  [ROOT_W+1];
  logic [ROOT_W-1:0]    sroot_q [ROOT_W+1];
  logic [ROOT_W-1:0]    sroot_d [ROOT_W+1];
  logic [ROOT_W-1:0]    scand   [ROOT_W+1];
  logic [QW-1:0]        scsq    [ROOT_W+1];
  logic signed [VW-1:0] svol_q  [ROOT_W+1];

  assign en         = !(sv_q[ROOT_W] && out_valid_q && out_stall_i);
  assign in_stall_o = busy_q || !en;
  assign accept     = in_valid_i && !in_stall_o;
  assign acc_load   = accept && (operation_i == OP_LOAD);
  assign acc_eval   = accept && (operation_i == OP_EVAL);
  assign issue      = acc_eval || (busy_q && en);
  assign rd_addr    = busy_q ? idx_q[cnt_q - 2'd1] : vertex_a_i;

  always_ff @(posedge clk_i) begin
    if (acc_load) begin
      store_mem[point_index_i] <= {coord_z_i, coord_y_i, coord_x_i};
    end
    if (issue) begin
      rd_q <= store_mem[rd_addr];
    end
  end

  always_comb begin
    emax_d = d2_q[0];
    for (int k = 1; k < 6; k++) begin
      if (d2_q[k] > emax_d) emax_d = d2_q[k];
    end
  end

  always_comb begin
    drem_d[0] = '0;
    dqt_d[0]  = '0;
    dsh[0]    = '0;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      dsh[k] = {drem_q[k-1], 1'b0};
      if (dsh[k] >= {1'b0, dl_q[k-1]}) begin
        drem_d[k] = REM_W'(dsh[k] - {1'b0, dl_q[k-1]});
        dqt_d[k]  = {dqt_q[k-1][QW-2:0], 1'b1};
      end else begin
        drem_d[k] = REM_W'(dsh[k]);
        dqt_d[k]  = {dqt_q[k-1][QW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    sroot_d[0] = '0;
    scand[0]   = '0;
    scsq[0]    = '0;
    for (int k = 1; k <= ROOT_W; k++) begin
      scand[k] = sroot_q[k-1] | (ROOT_W'(1) << (ROOT_W - k));
      scsq[k]  = QW'(scand[k]) * QW'(scand[k]);
      sroot_d[k] = (scsq[k] <= srad_q[k-1]) ? scand[k] : sroot_q[k-1];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= SLOT_A;
      rv_q   <= 1'b0;
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0; v9_q <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) dv_q[k] <= 1'b0;
      for (int k = 0; k <= ROOT_W; k++) sv_q[k] <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc_eval) begin
        busy_q <= 1'b1;
        cnt_q  <= SLOT_B;
      end else if (busy_q && en) begin
        if (cnt_q == SLOT_D) busy_q <= 1'b0;
        cnt_q <= cnt_q + 2'd1;
      end
      if (en) begin
        rv_q <= issue;
        v1_q <= rv_q && (rslot_q == SLOT_D);
        v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
        v6_q <= v5_q; v7_q <= v6_q; v8_q <= v7_q; v9_q <= v8_q;
        dv_q[0] <= v9_q;
        for (int k = 1; k <= DIV_STEPS; k++) dv_q[k] <= dv_q[k-1];
        sv_q[0] <= dv_q[DIV_STEPS];
        for (int k = 1; k <= ROOT_W; k++) sv_q[k] <= sv_q[k-1];
      end
      if (en && sv_q[ROOT_W]) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (acc_eval) begin
      idx_q[0] <= vertex_b_i;
      idx_q[1] <= vertex_c_i;
      idx_q[2] <= vertex_d_i;
    end
    if (en) begin
      rslot_q <= busy_q ? cnt_q : SLOT_A;
      if (rv_q) begin
        case (rslot_q)
          SLOT_A:  pa_q <= rd_q;
          SLOT_B:  pb_q <= rd_q;
          SLOT_C:  pc_q <= rd_q;
          default: ;
        endcase
      end

      edge_q[0] <= pdiff(pb_q, pa_q);
      edge_q[1] <= pdiff(pc_q, pa_q);
      edge_q[2] <= pdiff(rd_q, pa_q);
      edge_q[3] <= pdiff(pc_q, pb_q);
      edge_q[4] <= pdiff(rd_q, pb_q);
      edge_q[5] <= pdiff(rd_q, pc_q);

      xp_q[0] <= edge_q[1].y * edge_q[2].z;
      xp_q[1] <= edge_q[1].z * edge_q[2].y;
      xp_q[2] <= edge_q[1].z * edge_q[2].x;
      xp_q[3] <= edge_q[1].x * edge_q[2].z;
      xp_q[4] <= edge_q[1].x * edge_q[2].y;
      xp_q[5] <= edge_q[1].y * edge_q[2].x;
      for (int k = 0; k < 6; k++) begin
        sq_q[3*k]   <= SQ_W'(PW'(edge_q[k].x * edge_q[k].x));
        sq_q[3*k+1] <= SQ_W'(PW'(edge_q[k].y * edge_q[k].y));
        sq_q[3*k+2] <= SQ_W'(PW'(edge_q[k].z * edge_q[k].z));
      end
      e0_2_q <= edge_q[0];

      cr_q[0] <= CRW'(xp_q[0]) - CRW'(xp_q[1]);
      cr_q[1] <= CRW'(xp_q[2]) - CRW'(xp_q[3]);
      cr_q[2] <= CRW'(xp_q[4]) - CRW'(xp_q[5]);
      for (int k = 0; k < 6; k++) begin
        d2_q[k] <= E_W'(sq_q[3*k]) + E_W'(sq_q[3*k+1]) + E_W'(sq_q[3*k+2]);
      end
      e0_3_q <= e0_2_q;

      vp_q[0] <= e0_3_q.x * cr_q[0];
      vp_q[1] <= e0_3_q.y * cr_q[1];
      vp_q[2] <= e0_3_q.z * cr_q[2];
      emax_q  <= emax_d;

      vol5_q  <= VW'(vp_q[0]) + VW'(vp_q[1]) + VW'(vp_q[2]);
      e2_q    <= E2_W'(emax_q) * E2_W'(emax_q);
      emax5_q <= emax_q;

      vol6_q   <= vol5_q;
      mag_q    <= MAG_W'(vol5_q < 0 ? -vol5_q : vol5_q);
      e3p_q[0] <= E2_W'(e2_q[E2_W-1:E_W]) * E2_W'(emax5_q);
      e3p_q[1] <= E2_W'(e2_q[E_W-1:0]) * E2_W'(emax5_q);

      vol7_q <= vol6_q;
      z7_q   <= (mag_q == '0);
      vh_q   <= (2*HALF)'(mag_q[MAG_W-1:HALF]) * (2*HALF)'(mag_q[MAG_W-1:HALF]);
      vm_q   <= (2*HALF)'(mag_q[MAG_W-1:HALF]) * (2*HALF)'(mag_q[HALF-1:0]);
      vl_q   <= (2*HALF)'(mag_q[HALF-1:0]) * (2*HALF)'(mag_q[HALF-1:0]);
      e3_q   <= (E3_W'(e3p_q[0]) << E_W) + E3_W'(e3p_q[1]);

      vol8_q <= vol7_q;
      z8_q   <= z7_q;
      v2sq_q <= (V2_W'(vh_q) << (2*HALF)) + (V2_W'(vm_q) << (HALF + 1)) + V2_W'(vl_q);
      l8_q   <= L_W'(e3_q) * L_W'(QK_DEN);

      vol9_q <= vol8_q;
      z9_q   <= z8_q;
      l9_q   <= l8_q;
      m_q    <= M_W'(v2sq_q) * M_W'(QK_NUM);

      // quotient of (M << 34) by L; its low 32 numerator bits are zero
      drem_q[0] <= REM_W'({m_q, 2'b00});
      dsat_q[0] <= ({m_q, 2'b00} >= (M_W+2)'(l9_q));
      dl_q[0]   <= l9_q;
      dqt_q[0]  <= '0;
      dz_q[0]   <= z9_q;
      dvol_q[0] <= vol9_q;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        drem_q[k] <= drem_d[k];
        dqt_q[k]  <= dqt_d[k];
        dl_q[k]   <= dl_q[k-1];
        dsat_q[k] <= dsat_q[k-1];
        dz_q[k]   <= dz_q[k-1];
        dvol_q[k] <= dvol_q[k-1];
      end

      if (dz_q[DIV_STEPS]) srad_q[0] <= '0;
      else if (dsat_q[DIV_STEPS]) srad_q[0] <= '1;
      else srad_q[0] <= dqt_q[DIV_STEPS];
      sroot_q[0] <= '0;
      svol_q[0]  <= dvol_q[DIV_STEPS];
      for (int k = 1; k <= ROOT_W; k++) begin
        srad_q[k]  <= srad_q[k-1];
        sroot_q[k] <= sroot_d[k];
        svol_q[k]  <= svol_q[k-1];
      end

      if (sv_q[ROOT_W]) begin
        out_q_q   <= sroot_q[ROOT_W];
        out_vol_q <= svol_q[ROOT_W];
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign quality_o        = out_q_q;
  assign signed_volume6_o = out_vol_q;

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(acc_load && issue))
    else $error("store write collides with a vertex read");

  a_eval_holds_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_eval |=> busy_q && in_stall_o)
    else $error("input taken while vertex reads are pending");

  a_flat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && signed_volume6_o == '0) |-> quality_o == '0)
    else $error("flat tetrahedron with nonzero quality");

endmodule

`default_nettype wire
